// ----- rtl/tcce_pkg.sv -----
// shared constants, types and helpers for the text console cursor engine
package tcce_pkg;

    localparam int COLUMNS   = 80;
    localparam int ROWS      = 25;
    localparam int TERMINALS = 3;

    localparam int COL_W  = 7;
    localparam int ROW_W  = 5;
    localparam int POS_W  = 11;
    localparam int TERM_W = (TERMINALS > 1) ? $clog2(TERMINALS) : 1;

    localparam logic [7:0] CH_NEWLINE   = 8'd10;
    localparam logic [7:0] CH_RETURN    = 8'd13;
    localparam logic [7:0] CH_BACKSPACE = 8'd8;
    localparam logic [7:0] CH_SPACE     = 8'd32;
    localparam logic [7:0] ATTR_RESET   = 8'd7;

    localparam logic [1:0] OP_NONE  = 2'd0;
    localparam logic [1:0] OP_WRITE = 2'd1;
    localparam logic [1:0] OP_BLANK = 2'd2;

    localparam logic KIND_CHAR  = 1'b0;
    localparam logic KIND_CLEAR = 1'b1;

    typedef struct packed {
        logic [1:0]       cell_op;
        logic [POS_W-1:0] cell_index;
        logic [7:0]       cell_char;
        logic [7:0]       cell_attr;
        logic             scroll_up;
        logic             clear_screen;
        logic             cursor_update;
        logic [POS_W-1:0] cursor_pos;
    } t_result;

    // row * COLUMNS + col, kept to the low 11 bits
    function automatic logic [POS_W-1:0] cell_offset(input logic [ROW_W-1:0] row,
                                                     input logic [COL_W-1:0] col);
        logic [POS_W:0] full;
        full = (POS_W+1)'(row) * (POS_W+1)'(COLUMNS) + (POS_W+1)'(col);
        return full[POS_W-1:0];
    endfunction

endpackage

// ----- rtl/tcce_step.sv -----
// cursor update and cell write decode for one transaction
module tcce_step (
    input  logic                        i_term_ok,
    input  logic                        i_is_shown,
    input  logic                        i_kind,
    input  logic [7:0]                  i_char_code,
    input  logic [7:0]                  i_attr,
    input  logic [tcce_pkg::COL_W-1:0]  i_col,
    input  logic [tcce_pkg::ROW_W-1:0]  i_row,
    output logic                        o_write,
    output logic [tcce_pkg::COL_W-1:0]  o_col,
    output logic [tcce_pkg::ROW_W-1:0]  o_row,
    output tcce_pkg::t_result           o_res
);

    logic [tcce_pkg::ROW_W:0]   row_inc;
    logic [tcce_pkg::ROW_W-1:0] nl_row;
    logic                       nl_scroll;

    // start of next row, pinned at the bottom with a scroll
    always_comb begin
        row_inc = (tcce_pkg::ROW_W+1)'(i_row) + 1'b1;
        if (row_inc >= (tcce_pkg::ROW_W+1)'(tcce_pkg::ROWS)) begin
            nl_row    = tcce_pkg::ROW_W'(tcce_pkg::ROWS - 1);
            nl_scroll = 1'b1;
        end else begin
            nl_row    = row_inc[tcce_pkg::ROW_W-1:0];
            nl_scroll = 1'b0;
        end
    end

    always_comb begin
        o_write = 1'b0;
        o_col   = i_col;
        o_row   = i_row;
        o_res   = '0;
        if (i_term_ok) begin
            o_write = 1'b1;
            if (i_kind == tcce_pkg::KIND_CLEAR) begin
                o_col              = '0;
                o_row              = '0;
                o_res.cell_attr    = i_attr;
                o_res.clear_screen = 1'b1;
            end else if (i_char_code == tcce_pkg::CH_NEWLINE ||
                         i_char_code == tcce_pkg::CH_RETURN) begin
                o_col           = '0;
                o_row           = nl_row;
                o_res.scroll_up = nl_scroll;
                o_res.cell_attr = nl_scroll ? i_attr : 8'd0;
            end else if (i_char_code == tcce_pkg::CH_BACKSPACE) begin
                if (i_col != '0 || i_row != '0) begin
                    if (i_col == '0) begin
                        o_row = i_row - 1'b1;
                        o_col = tcce_pkg::COL_W'(tcce_pkg::COLUMNS - 1);
                    end else begin
                        o_col = i_col - 1'b1;
                    end
                    o_res.cell_op    = tcce_pkg::OP_BLANK;
                    o_res.cell_index = tcce_pkg::cell_offset(o_row, o_col);
                    o_res.cell_char  = tcce_pkg::CH_SPACE;
                end
            end else begin
                // full row wraps before the write
                if (i_col >= tcce_pkg::COL_W'(tcce_pkg::COLUMNS)) begin
                    o_col           = '0;
                    o_row           = nl_row;
                    o_res.scroll_up = nl_scroll;
                end
                o_res.cell_op    = tcce_pkg::OP_WRITE;
                o_res.cell_index = tcce_pkg::cell_offset(o_row, o_col);
                o_res.cell_char  = i_char_code;
                o_res.cell_attr  = i_attr;
                o_col            = o_col + 1'b1;
            end
            if (i_kind == tcce_pkg::KIND_CLEAR || i_is_shown) begin
                o_res.cursor_update = 1'b1;
                o_res.cursor_pos    = tcce_pkg::cell_offset(o_row, o_col);
            end
        end
    end

endmodule

// ----- rtl/text_console_cursor_engine_unit.sv -----
// result path: the input transaction is captured in the input register, decoded, and its result is
//   held in the result register until the receiver takes it
// one transaction per cycle while the receiver is ready; cursor state is updated as an item
//   leaves the input register, so the next item sees it without a bubble
// reset (synchronous, active low): cursors of all terminals at 0,0, attribute 7,
//   both pipeline registers empty
module text_console_cursor_engine_unit (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    output logic                           o_ready,
    input  logic                           i_kind,
    input  logic [7:0]                     i_char_code,
    input  logic                           i_from_keyboard,
    input  logic [1:0]                     i_shown_term,
    input  logic [1:0]                     i_running_term,
    output logic                           o_valid,
    input  logic                           i_ready,
    output logic [1:0]                     o_cell_op,
    output logic [tcce_pkg::POS_W-1:0]     o_cell_index,
    output logic [7:0]                     o_cell_char,
    output logic [7:0]                     o_cell_attr,
    output logic                           o_scroll_up,
    output logic                           o_clear_screen,
    output logic                           o_cursor_update,
    output logic [tcce_pkg::POS_W-1:0]     o_cursor_pos,
    input  logic                           i_attr_we,
    input  logic [7:0]                     i_attr_data
);

    logic                       r_in_valid;
    logic                       r_kind;
    logic [7:0]                 r_char_code;
    logic                       r_from_keyboard;
    logic [1:0]                 r_shown_term;
    logic [1:0]                 r_running_term;
    logic                       r_out_valid;
    tcce_pkg::t_result          r_res;
    logic [7:0]                 r_attr;
    logic [tcce_pkg::COL_W-1:0] r_col [tcce_pkg::TERMINALS];
    logic [tcce_pkg::ROW_W-1:0] r_row [tcce_pkg::TERMINALS];

    logic                       advance;
    logic [1:0]                 target;
    logic [1:0]                 sel;
    logic                       term_ok;
    logic [tcce_pkg::COL_W-1:0] cur_col;
    logic [tcce_pkg::ROW_W-1:0] cur_row;
    logic                       step_write;
    logic [tcce_pkg::COL_W-1:0] n_col;
    logic [tcce_pkg::ROW_W-1:0] n_row;
    tcce_pkg::t_result          n_res;

    assign advance = r_in_valid && (!r_out_valid || i_ready);
    assign o_ready = !r_in_valid || advance;

    always_comb begin
        target  = r_from_keyboard ? r_shown_term : r_running_term;
        sel     = (r_kind == tcce_pkg::KIND_CLEAR) ? r_shown_term : target;
        term_ok = (32'(sel) < tcce_pkg::TERMINALS);
        cur_col = '0;
        cur_row = '0;
        if (term_ok) begin
            cur_col = r_col[tcce_pkg::TERM_W'(sel)];
            cur_row = r_row[tcce_pkg::TERM_W'(sel)];
        end
    end

    tcce_step u_step (
        .i_term_ok   (term_ok),
        .i_is_shown  (target == r_shown_term),
        .i_kind      (r_kind),
        .i_char_code (r_char_code),
        .i_attr      (r_attr),
        .i_col       (cur_col),
        .i_row       (cur_row),
        .o_write     (step_write),
        .o_col       (n_col),
        .o_row       (n_row),
        .o_res       (n_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_attr      <= tcce_pkg::ATTR_RESET;
        end else begin
            if (o_ready) begin
                r_in_valid <= i_valid;
            end
            if (advance) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
            if (i_attr_we) begin
                r_attr <= i_attr_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_kind          <= i_kind;
            r_char_code     <= i_char_code;
            r_from_keyboard <= i_from_keyboard;
            r_shown_term    <= i_shown_term;
            r_running_term  <= i_running_term;
        end
        if (advance) begin
            r_res <= n_res;
        end
    end

    // per-terminal cursor state
    always_ff @(posedge i_clk) begin
        for (int t = 0; t < tcce_pkg::TERMINALS; t++) begin
            if (!i_rst_n) begin
                r_col[t] <= '0;
                r_row[t] <= '0;
            end else if (advance && step_write && 32'(sel) == t) begin
                r_col[t] <= n_col;
                r_row[t] <= n_row;
            end
        end
    end

    assign o_valid         = r_out_valid;
    assign o_cell_op       = r_res.cell_op;
    assign o_cell_index    = r_res.cell_index;
    assign o_cell_char     = r_res.cell_char;
    assign o_cell_attr     = r_res.cell_attr;
    assign o_scroll_up     = r_res.scroll_up;
    assign o_clear_screen  = r_res.clear_screen;
    assign o_cursor_update = r_res.cursor_update;
    assign o_cursor_pos    = r_res.cursor_pos;

endmodule

// ----- verif/tb_text_console_cursor_engine_unit.sv -----
// testbench for the text console cursor engine: directed table, random bursts, scoreboard
module tb_text_console_cursor_engine_unit;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int WATCHDOG_CYCLES = 5000;
    localparam int HOLD_CYCLES     = 60;
    localparam int DIR_STEPS       = 18;
    localparam int PHASE_ITEMS     = 285;

    typedef struct packed {
        logic       kind;
        logic [7:0] ch;
        logic       kbd;
        logic [1:0] shown;
        logic [1:0] running;
    } t_item;

    typedef struct packed {
        t_item             item;
        logic              pinned;
        tcce_pkg::t_result want;
    } t_dir_row;

    logic                       i_clk           = 1'b0;
    logic                       i_rst_n         = 1'b0;
    logic                       i_valid         = 1'b0;
    logic                       o_ready;
    logic                       i_kind          = 1'b0;
    logic [7:0]                 i_char_code     = 8'd0;
    logic                       i_from_keyboard = 1'b0;
    logic [1:0]                 i_shown_term    = 2'd0;
    logic [1:0]                 i_running_term  = 2'd0;
    logic                       o_valid;
    logic                       i_ready         = 1'b0;
    logic [1:0]                 o_cell_op;
    logic [tcce_pkg::POS_W-1:0] o_cell_index;
    logic [7:0]                 o_cell_char;
    logic [7:0]                 o_cell_attr;
    logic                       o_scroll_up;
    logic                       o_clear_screen;
    logic                       o_cursor_update;
    logic [tcce_pkg::POS_W-1:0] o_cursor_pos;
    logic                       i_attr_we       = 1'b0;
    logic [7:0]                 i_attr_data     = 8'd0;

    // shadow cursor state and attribute
    int         shadow_col [tcce_pkg::TERMINALS];
    int         shadow_row [tcce_pkg::TERMINALS];
    logic [7:0] text_attr;

    tcce_pkg::t_result pending_results [$];
    int         err_count    = 0;
    int         stall_cycles = 0;
    bit         steady       = 1'b0;
    bit         hold_req     = 1'b0;
    t_dir_row   dir_steps [DIR_STEPS];

    always #5 i_clk = ~i_clk;

    text_console_cursor_engine_unit u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_ready         (o_ready),
        .i_kind          (i_kind),
        .i_char_code     (i_char_code),
        .i_from_keyboard (i_from_keyboard),
        .i_shown_term    (i_shown_term),
        .i_running_term  (i_running_term),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_cell_op       (o_cell_op),
        .o_cell_index    (o_cell_index),
        .o_cell_char     (o_cell_char),
        .o_cell_attr     (o_cell_attr),
        .o_scroll_up     (o_scroll_up),
        .o_clear_screen  (o_clear_screen),
        .o_cursor_update (o_cursor_update),
        .o_cursor_pos    (o_cursor_pos),
        .i_attr_we       (i_attr_we),
        .i_attr_data     (i_attr_data)
    );

    function automatic logic [tcce_pkg::POS_W-1:0] screen_offset(input int row, input int col);
        return tcce_pkg::POS_W'(row * tcce_pkg::COLUMNS + col);
    endfunction

    // returns 1 when the terminal has to scroll
    function automatic logic line_feed(input int t);
        shadow_col[t] = 0;
        if (shadow_row[t] + 1 >= tcce_pkg::ROWS) begin
            shadow_row[t] = tcce_pkg::ROWS - 1;
            return 1'b1;
        end
        shadow_row[t] = shadow_row[t] + 1;
        return 1'b0;
    endfunction

    function automatic tcce_pkg::t_result advance_cursor(input t_item it);
        tcce_pkg::t_result r;
        int      t;
        logic    scr;
        r   = '0;
        scr = 1'b0;
        if (it.kind == tcce_pkg::KIND_CLEAR) begin
            if (it.shown >= tcce_pkg::TERMINALS) return r;
            shadow_col[it.shown] = 0;
            shadow_row[it.shown] = 0;
            r.cell_attr     = text_attr;
            r.clear_screen  = 1'b1;
            r.cursor_update = 1'b1;
            return r;
        end
        t = it.kbd ? int'(it.shown) : int'(it.running);
        if (t >= tcce_pkg::TERMINALS) return r;
        if (it.ch == tcce_pkg::CH_NEWLINE || it.ch == tcce_pkg::CH_RETURN) begin
            scr = line_feed(t);
        end else if (it.ch == tcce_pkg::CH_BACKSPACE) begin
            if (shadow_col[t] != 0 || shadow_row[t] != 0) begin
                if (shadow_col[t] == 0) begin
                    shadow_row[t] = shadow_row[t] - 1;
                    shadow_col[t] = tcce_pkg::COLUMNS - 1;
                end else begin
                    shadow_col[t] = shadow_col[t] - 1;
                end
                r.cell_op    = tcce_pkg::OP_BLANK;
                r.cell_index = screen_offset(shadow_row[t], shadow_col[t]);
                r.cell_char  = tcce_pkg::CH_SPACE;
            end
        end else begin
            // full row wraps before the write
            if (shadow_col[t] >= tcce_pkg::COLUMNS) scr = line_feed(t);
            r.cell_op     = tcce_pkg::OP_WRITE;
            r.cell_index  = screen_offset(shadow_row[t], shadow_col[t]);
            r.cell_char   = it.ch;
            shadow_col[t] = shadow_col[t] + 1;
        end
        if (r.cell_op == tcce_pkg::OP_WRITE || scr) r.cell_attr = text_attr;
        r.scroll_up = scr;
        if (t == int'(it.shown)) begin
            r.cursor_update = 1'b1;
            r.cursor_pos    = screen_offset(shadow_row[t], shadow_col[t]);
        end
        return r;
    endfunction

    function automatic logic [7:0] printable_byte();
        logic [7:0] b;
        do b = 8'($urandom_range(255));
        while (b == tcce_pkg::CH_NEWLINE || b == tcce_pkg::CH_RETURN ||
               b == tcce_pkg::CH_BACKSPACE);
        return b;
    endfunction

    // called in a clock step; returns in the step where the transaction is taken
    task automatic send_item(input t_item it, input logic pinned,
                             input tcce_pkg::t_result pinned_res);
        int      gap;
        tcce_pkg::t_result r;
        gap = 0;
        while (!steady && $urandom_range(99) < 37) gap++;
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid         <= 1'b1;
        i_kind          <= it.kind;
        i_char_code     <= it.ch;
        i_from_keyboard <= it.kbd;
        i_shown_term    <= it.shown;
        i_running_term  <= it.running;
        do @(posedge i_clk); while (!o_ready);
        r = advance_cursor(it);
        pending_results.push_back(pinned ? pinned_res : r);
    endtask

    task automatic drain_results();
        i_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_attr(input logic [7:0] v);
        i_attr_we   <= 1'b1;
        i_attr_data <= v;
        @(posedge i_clk);
        i_attr_we   <= 1'b0;
        text_attr = v;
    endtask

    // bursts of well-formed traffic at one terminal, mixed with noise
    task automatic random_phase(input int n_items);
        int    done;
        int    len;
        int    mode;
        int    tgt;
        int    k;
        t_item it;
        done = 0;
        while (done < n_items) begin
            mode = $urandom_range(99);
            tgt  = $urandom_range(tcce_pkg::TERMINALS - 1);
            if (mode < 30)      len = $urandom_range(20, 5);
            else if (mode < 55) len = $urandom_range(170, 60);
            else if (mode < 75) len = $urandom_range(40, 5);
            else if (mode < 90) len = $urandom_range(120, 5);
            else                len = $urandom_range(6, 1);
            for (k = 0; k < len && done < n_items; k++) begin
                it.kind    = tcce_pkg::KIND_CHAR;
                it.kbd     = 1'($urandom_range(1));
                it.shown   = 2'($urandom_range(3));
                it.running = 2'($urandom_range(3));
                it.ch      = printable_byte();
                if (mode < 30) begin
                    case ($urandom_range(19))
                        0: it.kind = tcce_pkg::KIND_CLEAR;
                        1: it.ch   = tcce_pkg::CH_NEWLINE;
                        2: it.ch   = tcce_pkg::CH_RETURN;
                        3: it.ch   = tcce_pkg::CH_BACKSPACE;
                        default: it.ch = 8'($urandom_range(255));
                    endcase
                end else begin
                    if (it.kbd) it.shown = 2'(tgt);
                    else        it.running = 2'(tgt);
                    if (mode < 55) begin
                        if ($urandom_range(29) == 0) it.ch = tcce_pkg::CH_NEWLINE;
                    end else if (mode < 75) begin
                        if ($urandom_range(3) != 0)
                            it.ch = $urandom_range(1) ? tcce_pkg::CH_NEWLINE
                                                      : tcce_pkg::CH_RETURN;
                    end else if (mode < 90) begin
                        if ($urandom_range(7) != 0) it.ch = tcce_pkg::CH_BACKSPACE;
                    end else if (k == 0) begin
                        it.kind  = tcce_pkg::KIND_CLEAR;
                        it.shown = 2'(tgt);
                    end
                end
                send_item(it, 1'b0, '0);
                if (it.kind == tcce_pkg::KIND_CLEAR ? it.shown < tcce_pkg::TERMINALS
                        : (it.kbd ? it.shown : it.running) < tcce_pkg::TERMINALS)
                    done++;
            end
        end
    endtask

    task automatic check_field(input string name, input int unsigned want_v,
                               input int unsigned got_v);
        if (want_v != got_v) begin
            $error("%s: expected %0d, got %0d", name, want_v, got_v);
            err_count++;
        end
    endtask

    // result checker
    always @(posedge i_clk) begin : result_check
        tcce_pkg::t_result want;
        if (i_rst_n && o_valid && i_ready) begin
            if (pending_results.size() == 0) begin
                $error("result transaction with nothing expected");
                err_count++;
            end else begin
                want = pending_results.pop_front();
                check_field("cell_op", want.cell_op, o_cell_op);
                check_field("cell_index", want.cell_index, o_cell_index);
                check_field("cell_char", want.cell_char, o_cell_char);
                check_field("cell_attr", want.cell_attr, o_cell_attr);
                check_field("scroll_up", want.scroll_up, o_scroll_up);
                check_field("clear_screen", want.clear_screen, o_clear_screen);
                check_field("cursor_update", want.cursor_update, o_cursor_update);
                check_field("cursor_pos", want.cursor_pos, o_cursor_pos);
            end
        end
    end

    // receiver backpressure, with one long hold-off on request
    initial begin : ready_drive
        forever begin
            @(posedge i_clk);
            if (hold_req) begin
                hold_req = 1'b0;
                i_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end else if (steady) begin
                i_ready <= 1'b1;
            end else begin
                i_ready <= ($urandom_range(99) >= 37);
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && o_ready) || (o_valid && i_ready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= WATCHDOG_CYCLES) begin
            $display("Simulation FAILED");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    initial begin : stimulus
        int i;
        int ph;
        for (i = 0; i < tcce_pkg::TERMINALS; i++) begin
            shadow_col[i] = 0;
            shadow_row[i] = 0;
        end
        text_attr = tcce_pkg::ATTR_RESET;

        dir_steps = '{
            '{'{tcce_pkg::KIND_CHAR,  8'h41,                  1'b1, 2'd0, 2'd1}, 1'b1,
              '{tcce_pkg::OP_WRITE, 11'd0, 8'h41, tcce_pkg::ATTR_RESET,
                1'b0, 1'b0, 1'b1, 11'd1}},
            '{'{tcce_pkg::KIND_CHAR,  tcce_pkg::CH_BACKSPACE, 1'b1, 2'd0, 2'd1}, 1'b1,
              '{tcce_pkg::OP_BLANK, 11'd0, tcce_pkg::CH_SPACE, 8'd0,
                1'b0, 1'b0, 1'b1, 11'd0}},
            // backspace at the origin does nothing
            '{'{tcce_pkg::KIND_CHAR,  tcce_pkg::CH_BACKSPACE, 1'b1, 2'd0, 2'd1}, 1'b1,
              '{tcce_pkg::OP_NONE, 11'd0, 8'd0, 8'd0, 1'b0, 1'b0, 1'b1, 11'd0}},
            // out-of-range terminal indexes are dropped
            '{'{tcce_pkg::KIND_CHAR,  8'h78,                  1'b1, 2'd3, 2'd0}, 1'b1, '0},
            '{'{tcce_pkg::KIND_CHAR,  8'h78,                  1'b0, 2'd0, 2'd3}, 1'b1, '0},
            '{'{tcce_pkg::KIND_CLEAR, 8'h00,                  1'b0, 2'd3, 2'd0}, 1'b1, '0},
            '{'{tcce_pkg::KIND_CHAR,  8'hFF,                  1'b0, 2'd0, 2'd2}, 1'b1,
              '{tcce_pkg::OP_WRITE, 11'd0, 8'hFF, tcce_pkg::ATTR_RESET,
                1'b0, 1'b0, 1'b0, 11'd0}},
            '{'{tcce_pkg::KIND_CHAR,  8'h00,                  1'b0, 2'd2, 2'd2}, 1'b1,
              '{tcce_pkg::OP_WRITE, 11'd1, 8'h00, tcce_pkg::ATTR_RESET,
                1'b0, 1'b0, 1'b1, 11'd2}},
            '{'{tcce_pkg::KIND_CHAR,  tcce_pkg::CH_NEWLINE,   1'b0, 2'd0, 2'd1}, 1'b0, '0},
            '{'{tcce_pkg::KIND_CHAR,  tcce_pkg::CH_RETURN,    1'b1, 2'd1, 2'd0}, 1'b0, '0},
            // backspace at column zero goes to the end of the row above
            '{'{tcce_pkg::KIND_CHAR,  tcce_pkg::CH_BACKSPACE, 1'b1, 2'd1, 2'd0}, 1'b0, '0},
            '{'{tcce_pkg::KIND_CHAR,  8'h7E,                  1'b1, 2'd1, 2'd0}, 1'b0, '0},
            // full row wraps before the write
            '{'{tcce_pkg::KIND_CHAR,  8'h55,                  1'b1, 2'd1, 2'd0}, 1'b0, '0},
            '{'{tcce_pkg::KIND_CHAR,  8'hAA,                  1'b0, 2'd1, 2'd0}, 1'b0, '0},
            '{'{tcce_pkg::KIND_CLEAR, 8'hFF,                  1'b1, 2'd1, 2'd3}, 1'b1,
              '{tcce_pkg::OP_NONE, 11'd0, 8'd0, tcce_pkg::ATTR_RESET,
                1'b0, 1'b1, 1'b1, 11'd0}},
            '{'{tcce_pkg::KIND_CLEAR, 8'h00,                  1'b0, 2'd0, 2'd2}, 1'b1,
              '{tcce_pkg::OP_NONE, 11'd0, 8'd0, tcce_pkg::ATTR_RESET,
                1'b0, 1'b1, 1'b1, 11'd0}},
            '{'{tcce_pkg::KIND_CHAR,  tcce_pkg::CH_BACKSPACE, 1'b0, 2'd3, 2'd2}, 1'b0, '0},
            '{'{tcce_pkg::KIND_CHAR,  8'h80,                  1'b1, 2'd2, 2'd3}, 1'b0, '0}
        };

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (i = 0; i < DIR_STEPS; i++)
            send_item(dir_steps[i].item, dir_steps[i].pinned, dir_steps[i].want);

        for (ph = 0; ph < 4; ph++) begin
            drain_results();
            case (ph)
                0:       write_attr(8'hFF);
                1:       write_attr(8'h00);
                default: write_attr(8'($urandom_range(254, 1)));
            endcase
            steady = (ph == 2);
            if (ph == 1) hold_req = 1'b1;
            random_phase(PHASE_ITEMS);
        end
        steady = 1'b0;

        drain_results();
        repeat (6) @(posedge i_clk);
        if (err_count == 0 && pending_results.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

// ----- sim.f -----
rtl/tcce_pkg.sv
rtl/tcce_step.sv
rtl/text_console_cursor_engine_unit.sv
verif/tb_text_console_cursor_engine_unit.sv
